/* sv/m4cma_pkg.sv */
// ----------------------------------------------------------------------------
// m4cma_pkg
// Shared types and request codes for the 4x4 column multiply-accumulate core.
// ----------------------------------------------------------------------------
package m4cma_pkg;

  // One matrix element, signed fixed point
  typedef logic signed [31:0] word_t;

  // One matrix column, element 0 is row 0
  typedef word_t [3:0] colv_t;

  // Request codes
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_MUL   = 2'd1;
  localparam logic [1:0] REQ_IDENT = 2'd2;

  // Last column: a multiply on it commits the product matrix
  localparam logic [1:0] LAST_COL = 2'd3;

  // Saturation rails
  localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN = 32'sh8000_0000;

  // Second-stage control, handed from the core to the merge stage
  typedef struct packed {
    logic       valid;
    logic       is_mul;
    logic [1:0] col;
  } s1_ctl_t;

endpackage

/* sv/m4cma_lane.sv */
// ----------------------------------------------------------------------------
// m4cma_lane
// One row lane: four 32x32 products registered, then exact sum, arithmetic
// shift by FRAC_BITS and saturation to 32 bits.
// ----------------------------------------------------------------------------
module m4cma_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             en,
  input  m4cma_pkg::colv_t op,    // operand column, element k
  input  m4cma_pkg::colv_t arow,  // current matrix row, element k is column k
  output m4cma_pkg::word_t res,
  output logic             sat
);

  localparam int SUM_W = 66;

  logic signed [63:0]      prod_r [4];
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] shifted;
  logic [SUM_W-32:0]       upper;

  // Product registers, one multiplier per element
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        prod_r[k] <= 64'(op[k]) * 64'(arow[k]);
      end
    end
  end

  // Exact sum, floor shift, range check
  always_comb begin
    sum     = SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]) +
              SUM_W'(prod_r[2]) + SUM_W'(prod_r[3]);
    shifted = sum >>> FRAC_BITS;
    upper   = shifted[SUM_W-1:31];
    if ((&upper) || (~|upper)) begin
      res = shifted[31:0];
      sat = 1'b0;
    end else begin
      res = shifted[SUM_W-1] ? m4cma_pkg::WORD_MIN : m4cma_pkg::WORD_MAX;
      sat = 1'b1;
    end
  end

endmodule

/* sv/m4cma_merge.sv */
// ----------------------------------------------------------------------------
// m4cma_merge
// Merges the four lane results into one column, or passes the stored column
// through, and holds it in the output register.
// ----------------------------------------------------------------------------
module m4cma_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  m4cma_pkg::s1_ctl_t  ctl,
  input  m4cma_pkg::colv_t    lane_res,
  input  logic [3:0]          lane_sat,
  input  m4cma_pkg::colv_t    pass,
  output logic                out_free,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_col,
  output m4cma_pkg::colv_t    out_res,
  output logic                out_saturated
);

  logic             out_v_r;
  logic             out_v_nxt;
  logic [1:0]       col_r;
  m4cma_pkg::colv_t res_r;
  logic             sat_r;
  logic             load;

  assign out_free = !out_v_r || !out_stall;
  assign load     = ctl.valid && out_free;

  // Output valid
  always_comb begin
    if (load) begin
      out_v_nxt = 1'b1;
    end else if (out_free) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  // Output payload: lane product or passed-through column
  always_ff @(posedge clk) begin
    if (load) begin
      col_r <= ctl.col;
      res_r <= ctl.is_mul ? lane_res : pass;
      sat_r <= ctl.is_mul && (|lane_sat);
    end
  end

  assign out_valid     = out_v_r;
  assign out_col       = col_r;
  assign out_res       = res_r;
  assign out_saturated = sat_r;

endmodule

/* sv/mat4_column_multiply_accumulate_core.sv */
// ----------------------------------------------------------------------------
// mat4_column_multiply_accumulate_core
// Current 4x4 column-major matrix updated as current times operand, one
// column per transaction, four row lanes and a merging output stage.
// ----------------------------------------------------------------------------
// An accepted input is registered in the adder stage, then in the output register.
// Throughput: one transaction per cycle while the output is not stalled; a column-3
//   multiply (commit) holds the input while its product is written back from the
//   lane adder stage into the current matrix.
// Reset (synchronous, rst_n low): current matrix to identity, pending product
//   columns to zero, pipeline empty.
module mat4_column_multiply_accumulate_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_req_type,
  input  logic [1:0]          in_col_index,
  input  logic signed [31:0]  in_val0,
  input  logic signed [31:0]  in_val1,
  input  logic signed [31:0]  in_val2,
  input  logic signed [31:0]  in_val3,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_col,
  output logic signed [31:0]  out_res0,
  output logic signed [31:0]  out_res1,
  output logic signed [31:0]  out_res2,
  output logic signed [31:0]  out_res3,
  output logic                out_saturated
);

  localparam m4cma_pkg::word_t ONE = 32'sd1 <<< FRAC_BITS;

  m4cma_pkg::word_t   mat_r  [16];
  m4cma_pkg::word_t   pend_r [12];
  m4cma_pkg::colv_t   in_vals;
  m4cma_pkg::colv_t   pass_nxt;
  m4cma_pkg::colv_t   s1_pass_r;
  m4cma_pkg::colv_t   lane_res;
  m4cma_pkg::colv_t   out_res;
  m4cma_pkg::colv_t   arow [4];
  logic [3:0]         lane_sat;
  logic               s1_v_r;
  logic               s1_mul_r;
  logic [1:0]         s1_col_r;
  m4cma_pkg::s1_ctl_t s1_ctl;
  logic               out_free;
  logic               s1_free;
  logic               s1_move;
  logic               commit_s1;
  logic               in_acc;
  logic               do_load;
  logic               do_ident;

  assign in_vals = {in_val3, in_val2, in_val1, in_val0};

  // Handshake and hazard: hold input while a commit sits in the adder stage
  assign s1_free   = !s1_v_r || out_free;
  assign s1_move   = s1_v_r && out_free;
  assign commit_s1 = s1_v_r && s1_mul_r && (s1_col_r == m4cma_pkg::LAST_COL);
  assign in_stall  = !s1_free || commit_s1;
  assign in_acc    = in_valid && !in_stall;

  // Request decode
  always_comb begin
    do_load  = 1'b0;
    do_ident = 1'b0;
    unique case (in_req_type)
      m4cma_pkg::REQ_LOAD:  do_load  = 1'b1;
      m4cma_pkg::REQ_IDENT: do_ident = 1'b1;
      default: ;
    endcase
  end

  // Column seen after the transaction, for non-multiply requests
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (do_load) begin
        pass_nxt[i] = in_vals[i];
      end else if (do_ident) begin
        pass_nxt[i] = (in_col_index == 2'(i)) ? ONE : '0;
      end else begin
        pass_nxt[i] = mat_r[{in_col_index, 2'(i)}];
      end
    end
  end

  // Current matrix: reset/identity, load, commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        mat_r[i] <= (i % 5 == 0) ? ONE : '0;
      end
    end else if (s1_move && commit_s1) begin
      for (int i = 0; i < 12; i++) begin
        mat_r[i] <= pend_r[i];
      end
      for (int i = 0; i < 4; i++) begin
        mat_r[12 + i] <= lane_res[i];
      end
    end else if (in_acc && do_load) begin
      for (int i = 0; i < 4; i++) begin
        mat_r[{in_col_index, 2'(i)}] <= in_vals[i];
      end
    end else if (in_acc && do_ident) begin
      for (int i = 0; i < 16; i++) begin
        mat_r[i] <= (i % 5 == 0) ? ONE : '0;
      end
    end
  end

  // Pending product columns 0..2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 12; i++) begin
        pend_r[i] <= '0;
      end
    end else if (s1_move && s1_mul_r && !commit_s1) begin
      for (int i = 0; i < 4; i++) begin
        pend_r[{s1_col_r, 2'(i)}] <= lane_res[i];
      end
    end
  end

  // Adder stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_move) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mul_r  <= (in_req_type == m4cma_pkg::REQ_MUL);
      s1_col_r  <= in_col_index;
      s1_pass_r <= pass_nxt;
    end
  end

  assign s1_ctl = '{valid: s1_v_r, is_mul: s1_mul_r, col: s1_col_r};

  // Row lanes
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int k = 0; k < 4; k++) begin
        arow[r][k] = mat_r[{2'(k), 2'(r)}];
      end
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_lane
    m4cma_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk  (clk),
      .en   (in_acc),
      .op   (in_vals),
      .arow (arow[r]),
      .res  (lane_res[r]),
      .sat  (lane_sat[r])
    );
  end

  // Merge and output register
  m4cma_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (s1_ctl),
    .lane_res      (lane_res),
    .lane_sat      (lane_sat),
    .pass          (s1_pass_r),
    .out_free      (out_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_col       (out_col),
    .out_res       (out_res),
    .out_saturated (out_saturated)
  );

  assign out_res0 = out_res[0];
  assign out_res1 = out_res[1];
  assign out_res2 = out_res[2];
  assign out_res3 = out_res[3];

`ifndef SYNTH
  // No transaction enters behind a commit still in the adder stage
  a_commit_hazard: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !commit_s1)
    else $error("input accepted while commit pending");

  // A blocked adder stage keeps its transaction
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !out_free) |=> (s1_v_r && $stable(s1_col_r) && $stable(s1_mul_r)))
    else $error("adder stage lost a transaction");

  // Saturation flag implies a clipped element on a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_res0 == m4cma_pkg::WORD_MAX || out_res0 == m4cma_pkg::WORD_MIN ||
       out_res1 == m4cma_pkg::WORD_MAX || out_res1 == m4cma_pkg::WORD_MIN ||
       out_res2 == m4cma_pkg::WORD_MAX || out_res2 == m4cma_pkg::WORD_MIN ||
       out_res3 == m4cma_pkg::WORD_MAX || out_res3 == m4cma_pkg::WORD_MIN))
    else $error("saturated flag without a rail value");
`endif

endmodule
